// ===== rtl/sha1h_pkg.sv =====
package sha1h_pkg;

    // Queue between the front end and the hash engine
    localparam int QUEUE_AW_DEF = 2;

    // Port widths
    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 40;

    // Byte positions inside a 64-byte block, and the last round index
    localparam logic [5:0] BLOCK_LAST_POS = 6'd63;
    localparam logic [5:0] LEN_POS        = 6'd56;
    localparam logic [6:0] ROUND_LAST     = 7'd79;

    // Padding marker byte
    localparam logic [7:0] PAD_MARK = 8'h80;

    // Digest word positions
    localparam logic [2:0] WORD_FIRST = 3'd0;
    localparam logic [2:0] WORD_LAST  = 3'd4;

    // Round groups, one per 20 rounds
    localparam logic [1:0] GRP_CH     = 2'd0;
    localparam logic [1:0] GRP_PAR1   = 2'd1;
    localparam logic [1:0] GRP_MAJ    = 2'd2;
    localparam logic [1:0] GRP_PAR2   = 2'd3;

    localparam logic [31:0] ROUND_K [4] = '{
        32'h5A827999, 32'h6ED9EBA1, 32'h8F1BBCDC, 32'hCA62C1D6
    };

    localparam logic [31:0] INIT_H [5] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };

    // One queued item: a message byte and/or end of message
    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       end_of_message;
    } item_t;

    function automatic logic [31:0] rotl(input logic [31:0] x, input int unsigned n);
        logic [63:0] dbl;
        dbl = {x, x} << n;
        return dbl[63:32];
    endfunction

    function automatic logic [31:0] round_f(input logic [1:0] grp, input logic [31:0] b,
                                            input logic [31:0] c, input logic [31:0] d);
        logic [31:0] res;
        case (grp)
            GRP_CH:   res = (b & c) | (~b & d);
            GRP_MAJ:  res = (b & c) | (b & d) | (c & d);
            GRP_PAR1: res = b ^ c ^ d;
            GRP_PAR2: res = b ^ c ^ d;
            default:  res = b ^ c ^ d;
        endcase
        return res;
    endfunction

endpackage

// ===== rtl/sha1h_front.sv =====
module sha1h_front #(
    parameter int QUEUE_AW = sha1h_pkg::QUEUE_AW_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,
    input  logic                  s_tuser,
    input  logic                  s_tlast,
    output logic                  item_valid,
    input  logic                  item_ready,
    output sha1h_pkg::item_t      item
);
    import sha1h_pkg::*;

    localparam int DEPTH = 1 << QUEUE_AW;

    item_t               q_mem_reg [DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg;
    logic [QUEUE_AW-1:0] rd_ptr_reg;
    logic [QUEUE_AW:0]   count_reg;
    logic                push;
    logic                pop;
    item_t               in_item;

    // Classify: items with neither byte nor end are taken and dropped
    assign in_item  = '{data_byte: s_tdata, has_byte: s_tuser, end_of_message: s_tlast};
    assign s_tready = (count_reg != (QUEUE_AW+1)'(DEPTH));
    assign push     = s_tvalid && s_tready && (s_tuser || s_tlast);
    assign item_valid = (count_reg != '0);
    assign pop      = item_valid && item_ready;
    assign item     = q_mem_reg[rd_ptr_reg];

    // Hold queued items
    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem_reg[wr_ptr_reg] <= in_item;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ===== rtl/sha1h_engine.sv =====
module sha1h_engine (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              item_valid,
    output logic              item_ready,
    input  sha1h_pkg::item_t  item,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [39:0]       m_tdata,
    output logic              m_tlast
);
    import sha1h_pkg::*;

    typedef enum logic [2:0] {ST_IDLE, ST_ROUND, ST_CHAIN, ST_PAD, ST_EMIT} state_t;

    state_t      state_reg;
    logic [31:0] h_reg [5];
    logic [31:0] win_reg [16];
    logic [23:0] acc_reg;
    logic [5:0]  pos_reg;
    logic [60:0] count_reg;
    logic [63:0] len_reg;
    logic        pad_active_reg;
    logic        pad_first_reg;
    logic        len_mode_reg;
    logic [6:0]  rnd_reg;
    logic [31:0] a_reg, b_reg, c_reg, d_reg, e_reg;
    logic        out_valid_reg;
    logic [31:0] out_word_reg;
    logic [2:0]  out_idx_reg;
    logic        out_last_reg;

    logic        put_en;
    logic [7:0]  put_byte;
    logic [31:0] new_word;
    logic        block_full;
    logic [31:0] sched_word;
    logic [1:0]  grp;
    logic [31:0] t_word;
    logic [2:0]  out_idx_next;
    logic [60:0] count_next;

    assign item_ready = (state_reg == ST_IDLE);
    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = {5'd0, out_idx_reg, out_word_reg};
    assign m_tlast    = out_last_reg;

    // Select the byte to pack: message byte in idle, padding or length in pad
    always_comb begin
        put_en   = 1'b0;
        put_byte = item.data_byte;
        case (state_reg)
            ST_IDLE: begin
                put_en = item_valid && item.has_byte;
            end
            ST_PAD: begin
                put_en = 1'b1;
                if (pad_first_reg) begin
                    put_byte = PAD_MARK;
                end else if (len_mode_reg || pos_reg == LEN_POS) begin
                    put_byte = len_reg[63:56];
                end else begin
                    put_byte = 8'h00;
                end
            end
            default: begin
                put_en = 1'b0;
            end
        endcase
    end

    assign new_word   = {acc_reg, put_byte};
    assign block_full = put_en && (pos_reg == BLOCK_LAST_POS);
    assign count_next = count_reg + 61'(item.has_byte);

    // Round datapath: schedule word and new working word
    assign sched_word = rotl(win_reg[13] ^ win_reg[8] ^ win_reg[2] ^ win_reg[0], 1);

    always_comb begin
        if (rnd_reg < 7'd20) begin
            grp = GRP_CH;
        end else if (rnd_reg < 7'd40) begin
            grp = GRP_PAR1;
        end else if (rnd_reg < 7'd60) begin
            grp = GRP_MAJ;
        end else begin
            grp = GRP_PAR2;
        end
    end

    assign t_word = rotl(a_reg, 5) + round_f(grp, b_reg, c_reg, d_reg) + e_reg
                  + win_reg[0] + ROUND_K[grp];

    assign out_idx_next = out_idx_reg + 3'd1;

    // Sequencer: pack bytes, run rounds, chain, pad, emit digest
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            h_reg          <= INIT_H;
            pos_reg        <= '0;
            count_reg      <= '0;
            pad_active_reg <= 1'b0;
            pad_first_reg  <= 1'b0;
            len_mode_reg   <= 1'b0;
            rnd_reg        <= '0;
            out_valid_reg  <= 1'b0;
            out_last_reg   <= 1'b0;
            out_idx_reg    <= WORD_FIRST;
        end else begin
            // Pack a byte; every fourth byte shifts a word into the window
            if (put_en) begin
                acc_reg <= new_word[23:0];
                pos_reg <= pos_reg + 6'd1;
                if (pos_reg[1:0] == 2'd3) begin
                    for (int i = 0; i < 15; i++) begin
                        win_reg[i] <= win_reg[i+1];
                    end
                    win_reg[15] <= new_word;
                end
            end
            if (block_full) begin
                a_reg   <= h_reg[0];
                b_reg   <= h_reg[1];
                c_reg   <= h_reg[2];
                d_reg   <= h_reg[3];
                e_reg   <= h_reg[4];
                rnd_reg <= '0;
            end

            case (state_reg)
                ST_IDLE: begin
                    if (item_valid) begin
                        count_reg <= count_next;
                        if (item.end_of_message) begin
                            len_reg        <= {count_next, 3'b000};
                            pad_active_reg <= 1'b1;
                            pad_first_reg  <= 1'b1;
                            len_mode_reg   <= 1'b0;
                        end
                        if (block_full) begin
                            state_reg <= ST_ROUND;
                        end else if (item.end_of_message) begin
                            state_reg <= ST_PAD;
                        end
                    end
                end
                ST_ROUND: begin
                    e_reg <= d_reg;
                    d_reg <= c_reg;
                    c_reg <= rotl(b_reg, 30);
                    b_reg <= a_reg;
                    a_reg <= t_word;
                    for (int i = 0; i < 15; i++) begin
                        win_reg[i] <= win_reg[i+1];
                    end
                    win_reg[15] <= sched_word;
                    rnd_reg <= rnd_reg + 7'd1;
                    if (rnd_reg == ROUND_LAST) begin
                        state_reg <= ST_CHAIN;
                    end
                end
                ST_CHAIN: begin
                    h_reg[0] <= h_reg[0] + a_reg;
                    h_reg[1] <= h_reg[1] + b_reg;
                    h_reg[2] <= h_reg[2] + c_reg;
                    h_reg[3] <= h_reg[3] + d_reg;
                    h_reg[4] <= h_reg[4] + e_reg;
                    if (pad_active_reg && len_mode_reg) begin
                        state_reg     <= ST_EMIT;
                        out_valid_reg <= 1'b1;
                        out_word_reg  <= h_reg[0] + a_reg;
                        out_idx_reg   <= WORD_FIRST;
                        out_last_reg  <= 1'b0;
                    end else if (pad_active_reg) begin
                        state_reg <= ST_PAD;
                    end else begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_PAD: begin
                    if (pad_first_reg) begin
                        pad_first_reg <= 1'b0;
                    end else if (len_mode_reg || pos_reg == LEN_POS) begin
                        len_mode_reg <= 1'b1;
                        len_reg      <= {len_reg[55:0], 8'h00};
                    end
                    if (block_full) begin
                        state_reg <= ST_ROUND;
                    end
                end
                ST_EMIT: begin
                    if (m_tready) begin
                        if (out_idx_reg == WORD_LAST) begin
                            out_valid_reg  <= 1'b0;
                            out_last_reg   <= 1'b0;
                            state_reg      <= ST_IDLE;
                            h_reg          <= INIT_H;
                            count_reg      <= '0;
                            pad_active_reg <= 1'b0;
                            len_mode_reg   <= 1'b0;
                        end else begin
                            out_idx_reg  <= out_idx_next;
                            out_word_reg <= h_reg[out_idx_next];
                            out_last_reg <= (out_idx_next == WORD_LAST);
                        end
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== rtl/sha1_byte_stream_hasher.sv =====
// SHA-1 over a byte stream. Bytes wait in a short queue and are packed at one per cycle
// while the engine is idle; each full 64-byte block then runs 80 rounds in one shared
// round unit, then the chaining add, and no byte is taken until that is done.
// On end of message: 9 to 72 padding and length bytes at one per cycle between blocks,
// one or two blocks, then the five digest words, the first set up by the last chaining add.
// Reset is synchronous and active low: it empties the queue and restores the initial hash.
module sha1_byte_stream_hasher #(
    parameter int QUEUE_AW = sha1h_pkg::QUEUE_AW_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // [0] has_byte
    input  logic        s_tlast,   // end_of_message
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [31:0] digest_word, [34:32] word_index, [39:35] zero
    output logic        m_tlast    // last_word
);
    import sha1h_pkg::*;

    logic  item_valid;
    logic  item_ready;
    item_t item;

    sha1h_front #(
        .QUEUE_AW (QUEUE_AW)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .s_tlast    (s_tlast),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item)
    );

    sha1h_engine u_engine (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

    // Engine takes no queued item while the digest is going out
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !item_ready)
        else $error("engine took an item while emitting the digest");

    // Final word of the digest carries the last position
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |-> (m_tdata[34:32] == WORD_LAST))
        else $error("last word flagged at wrong position");

    // Digest words come out in order
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && !m_tlast) |=>
            (m_tvalid && m_tdata[34:32] == 3'($past(m_tdata[34:32]) + 3'd1)))
        else $error("digest word position did not advance");

endmodule

// ===== tb/tb_sha1_byte_stream_hasher.sv =====
module tb_sha1_byte_stream_hasher;
    import sha1h_pkg::*;

    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 5;
    localparam int RANDOM_ITEMS = 500;
    localparam int HOLD_CYCLES  = 3000;
    localparam int DRAIN_CYCLES = 200;
    localparam int CYCLE_LIMIT  = 2000000;

    // Message lengths around the padding and block boundaries
    localparam int BOUNDARY_LENS [8] = '{55, 56, 57, 63, 64, 65, 119, 120};

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  pos;
        logic        last;
    } digest_word_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // [7:0] data_byte
    logic        s_tuser;   // [0] has_byte
    logic        s_tlast;   // end_of_message
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;   // [31:0] digest_word, [34:32] word_index, [39:35] zero
    logic        m_tlast;   // last_word

    // Digest model state
    logic [31:0] hash_chain [5];
    logic [31:0] block_buf [16];
    logic [5:0]  fill_pos;
    logic [60:0] byte_count;

    digest_word_t digest_q [$];
    int           errors;
    int           items_sent;
    int           rx_hold;
    int           rx_idle;
    bit           no_idle;

    sha1_byte_stream_hasher u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #(CLK_PERIOD / 2) aclk = ~aclk;
    end

    // Abort a hung run
    initial begin
        repeat (CYCLE_LIMIT) @(posedge aclk);
        $display("FAIL");
        $finish;
    end

    function automatic logic [31:0] rot_left(input logic [31:0] x, input int n);
        return (x << n) | (x >> (32 - n));
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic void restart_chain();
        for (int i = 0; i < 5; i++) hash_chain[i] = INIT_H[i];
        fill_pos   = '0;
        byte_count = '0;
    endfunction

    // Run the 80 rounds over the buffered block and fold into the chain
    function automatic void compress_block();
        logic [31:0] w [80];
        logic [31:0] a, b, c, d, e, f, t;
        for (int r = 0; r < 16; r++) w[r] = block_buf[r];
        for (int r = 16; r < 80; r++)
            w[r] = rot_left(w[r-3] ^ w[r-8] ^ w[r-14] ^ w[r-16], 1);
        a = hash_chain[0];
        b = hash_chain[1];
        c = hash_chain[2];
        d = hash_chain[3];
        e = hash_chain[4];
        for (int r = 0; r < 80; r++) begin
            if (r < 20)
                f = (b & c) | (~b & d);
            else if (r < 40 || r >= 60)
                f = b ^ c ^ d;
            else
                f = (b & c) | (b & d) | (c & d);
            t = rot_left(a, 5) + f + e + w[r] + ROUND_K[r / 20];
            e = d;
            d = c;
            c = rot_left(b, 30);
            b = a;
            a = t;
        end
        hash_chain[0] += a;
        hash_chain[1] += b;
        hash_chain[2] += c;
        hash_chain[3] += d;
        hash_chain[4] += e;
    endfunction

    // Place one byte big-endian into the block, compress when full
    function automatic void absorb_byte(input logic [7:0] v);
        int sh;
        int idx;
        idx = fill_pos[5:2];
        sh  = (3 - fill_pos[1:0]) * 8;
        block_buf[idx] = (block_buf[idx] & ~(32'hFF << sh)) | ({24'b0, v} << sh);
        if (fill_pos == 6'd63) begin
            compress_block();
            fill_pos = '0;
        end else begin
            fill_pos = fill_pos + 6'd1;
        end
    endfunction

    // Predict the digest words caused by one accepted item
    function automatic void predict_digest(input logic [7:0] data, input logic has,
                                           input logic eom);
        logic [63:0]  bit_len;
        digest_word_t dw;
        if (has) begin
            absorb_byte(data);
            byte_count = byte_count + 61'd1;
        end
        if (eom) begin
            bit_len = {byte_count, 3'b000};
            absorb_byte(PAD_MARK);
            while (fill_pos != LEN_POS) absorb_byte(8'h00);
            for (int k = 0; k < 8; k++) absorb_byte(bit_len[63 - 8*k -: 8]);
            for (int k = 0; k < 5; k++) begin
                dw.word = hash_chain[k];
                dw.pos  = 3'(k);
                dw.last = (3'(k) == WORD_LAST);
                digest_q.push_back(dw);
            end
            restart_chain();
        end
    endfunction

    // Offer one item after a random gap (none when no_idle is set) and hold it until the transfer
    task automatic send_item(input logic [7:0] data, input logic has, input logic eom);
        int gap;
        gap = no_idle ? 0 : pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tuser  <= has;
        s_tlast  <= eom;
        do @(posedge aclk); while (!s_tready);
        predict_digest(data, has, eom);
        if (has || eom) items_sent++;
    endtask

    // Check each transfer on the digest side and pace m_tready
    initial begin
        digest_word_t exp_w;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                if (digest_q.size() == 0) begin
                    $display("%0t: unexpected digest word %h index %0d last %0b",
                             $time, m_tdata[31:0], m_tdata[34:32], m_tlast);
                    errors++;
                end else begin
                    exp_w = digest_q.pop_front();
                    if (m_tdata[31:0] !== exp_w.word) begin
                        $display("%0t: digest_word expected %h actual %h",
                                 $time, exp_w.word, m_tdata[31:0]);
                        errors++;
                    end
                    if (m_tdata[34:32] !== exp_w.pos) begin
                        $display("%0t: word_index expected %0d actual %0d",
                                 $time, exp_w.pos, m_tdata[34:32]);
                        errors++;
                    end
                    if (m_tlast !== exp_w.last) begin
                        $display("%0t: last_word expected %0b actual %0b",
                                 $time, exp_w.last, m_tlast);
                        errors++;
                    end
                end
            end
            if (rx_hold > 0) begin
                rx_hold--;
                m_tready <= 1'b0;
            end else if (rx_idle > 0) begin
                rx_idle--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if (!no_idle && $urandom_range(0, 3) == 0) rx_idle = pick_gap();
            end
        end
    end

    task automatic test_empty_message();
        send_item(8'h00, 1'b0, 1'b1);
    endtask

    task automatic test_short_string();
        send_item("a", 1'b1, 1'b0);
        send_item("b", 1'b1, 1'b0);
        send_item("c", 1'b1, 1'b1);
    endtask

    // Extreme bytes, an ignored item, an end whose data must not count, and an end with a byte
    task automatic test_byte_extremes();
        send_item(8'h00, 1'b1, 1'b0);
        send_item(8'hFF, 1'b1, 1'b0);
        send_item(8'hA5, 1'b0, 1'b0);
        send_item(8'hFF, 1'b0, 1'b1);
        send_item(8'h80, 1'b1, 1'b1);
    endtask

    task automatic test_back_to_back_ends();
        no_idle = 1'b1;
        send_item(8'h5A, 1'b0, 1'b1);
        send_item(8'hC3, 1'b0, 1'b1);
        no_idle = 1'b0;
    endtask

    // Stall the digest side while messages keep coming, so the input backs up
    task automatic test_input_stall();
        no_idle = 1'b1;
        rx_hold = HOLD_CYCLES;
        for (int m = 0; m < 4; m++) begin
            for (int i = 0; i < 3; i++) send_item(8'($urandom_range(0, 255)), 1'b1, 1'b0);
            send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
        end
        no_idle = 1'b0;
    endtask

    task automatic test_random_messages();
        int  start;
        int  len;
        bit  tail_end;
        start = items_sent;
        while (items_sent - start < RANDOM_ITEMS) begin
            if ($urandom_range(0, 99) < 20)
                len = BOUNDARY_LENS[$urandom_range(0, 7)];
            else
                len = $urandom_range(0, 20);
            no_idle  = ($urandom_range(0, 3) == 0);
            tail_end = (len > 0) && ($urandom_range(0, 1) == 1);
            for (int i = 0; i < len; i++) begin
                if ($urandom_range(0, 19) == 0)
                    send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
                send_item(8'($urandom_range(0, 255)), 1'b1, tail_end && (i == len - 1));
            end
            if (!tail_end) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
        end
        no_idle = 1'b0;
    endtask

    initial begin
        errors     = 0;
        items_sent = 0;
        rx_hold    = 0;
        rx_idle    = 0;
        no_idle    = 1'b0;
        for (int i = 0; i < 16; i++) block_buf[i] = '0;
        restart_chain();
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= 8'h00;
        s_tuser  <= 1'b0;
        s_tlast  <= 1'b0;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_empty_message();
        test_short_string();
        test_byte_extremes();
        test_back_to_back_ends();
        test_input_stall();
        test_random_messages();

        // Let the last digests drain, then watch for stray transfers
        s_tvalid <= 1'b0;
        while (digest_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
